### rtl/core/assert_macros.svh
// Assertion macros shared by the checker files of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset
`define ASSERT_ON_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Signal group holds in the cycle after the condition
`define ASSERT_HOLD(lbl, clk, rst, cond, sig, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> $stable(sig)) else $error(msg);

`endif

### rtl/core/pcrar_pkg.sv
// Shared constants, codes and types of the paged cache row address resolver.
// No dependencies.
package pcrar_pkg;

   // Geometry
   localparam int MAX_SEQUENCES     = 64;
   localparam int MAX_TABLE_COLUMNS = 64;
   localparam int BLOCK_TOKENS      = 128;

   localparam int SEQ_W     = $clog2(MAX_SEQUENCES);
   localparam int COL_W     = $clog2(MAX_TABLE_COLUMNS);
   localparam int OFF_W     = $clog2(BLOCK_TOKENS);
   localparam int TBL_DEPTH = MAX_SEQUENCES * MAX_TABLE_COLUMNS;
   localparam int ADDR_W    = SEQ_W + COL_W;

   // Field widths
   localparam int OP_W        = 2;
   localparam int SEQIN_W     = 6;
   localparam int COLIN_W     = 6;
   localparam int WORD_W      = 32;
   localparam int PIDX_W      = 16;
   localparam int STATUS_W    = 4;
   localparam int BYTE_OFF_W  = 48;
   localparam int ROW_BYTES_W = 16;
   localparam int WIDTH_REG_W = 7;
   localparam int BLK_W       = 21;
   localparam int CAP_W       = 16;

   // Block column of a non-negative position, and derived row widths
   localparam int TOK_COL_W = WORD_W - 1 - OFF_W;
   localparam int ROW_W     = BLK_W + OFF_W;
   localparam int PROD_W    = ROW_W + ROW_BYTES_W;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_BYTES  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SRC_WIDTH  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DST_WIDTH  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SRC_LIMIT  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DST_LIMIT  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAIR_CAP   = 3'd5;

   // Register reset values
   localparam logic [ROW_BYTES_W-1:0] RST_ROW_BYTES = 16'd656;
   localparam logic [WIDTH_REG_W-1:0] RST_WIDTH     = 7'd64;
   localparam logic [BLK_W-1:0]       RST_LIMIT     = 21'd1048576;
   localparam logic [CAP_W-1:0]       RST_PAIR_CAP  = 16'd4096;

   // Request opcodes
   localparam logic [OP_W-1:0] OP_WR_SRC  = 2'd0;
   localparam logic [OP_W-1:0] OP_WR_DST  = 2'd1;
   localparam logic [OP_W-1:0] OP_RESOLVE = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 4'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_COUNT = 4'd1;
   localparam logic [STATUS_W-1:0] ST_NEG_TOK   = 4'd2;
   localparam logic [STATUS_W-1:0] ST_NEG_SLOT  = 4'd3;
   localparam logic [STATUS_W-1:0] ST_SRC_COL   = 4'd4;
   localparam logic [STATUS_W-1:0] ST_DST_COL   = 4'd5;
   localparam logic [STATUS_W-1:0] ST_SRC_NEG   = 4'd6;
   localparam logic [STATUS_W-1:0] ST_DST_NEG   = 4'd7;
   localparam logic [STATUS_W-1:0] ST_SRC_LIM   = 4'd8;
   localparam logic [STATUS_W-1:0] ST_DST_LIM   = 4'd9;

   // Table write command
   typedef struct packed {
      logic              src_en;
      logic              dst_en;
      logic [ADDR_W-1:0] addr;
      logic [WORD_W-1:0] data;
   } tbl_wr_type;

   // Table read command, one address per table
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] src_addr;
      logic [ADDR_W-1:0] dst_addr;
   } tbl_rd_type;

endpackage

### rtl/core/paged_cache_row_address_resolver.sv
// Top level of the paged cache row address resolver: checks, table lookup, byte offsets.
// Depends on pcrar_pkg and pcrar_tables.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | op, seq, column, value, pair, count, token, slot
//   rsp     | out       | rsp_valid/rsp_stall | source/dest byte offset, status
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// One request per cycle while req_stall is low. A resolve gives a result only if the count
// is bad or the index is below it; each table's single read port sets one lookup per cycle.
// Reset loads the register defaults and empties the pipeline; the tables are not cleared.
// rsp_stall holds the three pipeline registers; req_stall rises only once all are full.
// csr_ready is always high; table writes land at acceptance, so no forwarding is needed.
module paged_cache_row_address_resolver
   import pcrar_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [OP_W-1:0]               req_op,
   input  logic [SEQIN_W-1:0]            req_seq_index,
   input  logic [COLIN_W-1:0]            req_table_column,
   input  logic signed [WORD_W-1:0]      req_table_value,
   input  logic [PIDX_W-1:0]             req_pair_index,
   input  logic signed [WORD_W-1:0]      req_pair_count,
   input  logic signed [WORD_W-1:0]      req_source_token,
   input  logic signed [WORD_W-1:0]      req_dest_slot,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [BYTE_OFF_W-1:0]         rsp_source_byte_offset,
   output logic [BYTE_OFF_W-1:0]         rsp_dest_byte_offset,
   output logic [STATUS_W-1:0]           rsp_status,
   // configuration
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_data
);

   // Configuration registers
   logic [ROW_BYTES_W-1:0] row_bytes_ff;
   logic [WIDTH_REG_W-1:0] src_width_ff;
   logic [WIDTH_REG_W-1:0] dst_width_ff;
   logic [BLK_W-1:0]       src_limit_ff;
   logic [BLK_W-1:0]       dst_limit_ff;
   logic [CAP_W-1:0]       pair_cap_ff;

   // Pipeline
   logic                 s1_valid_ff, s1_valid_in;
   logic [STATUS_W-1:0]  s1_status_ff, s1_status_in;
   logic [OFF_W-1:0]     s1_soff_ff, s1_doff_ff;
   logic                 s2_valid_ff;
   logic [STATUS_W-1:0]  s2_status_ff, s2_status_in;
   logic [ROW_W-1:0]     s2_srow_ff, s2_drow_ff;
   logic                 rsp_valid_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [BYTE_OFF_W-1:0] rsp_src_ff, rsp_src_in;
   logic [BYTE_OFF_W-1:0] rsp_dst_ff, rsp_dst_in;

   logic rsp_free, s2_free, s1_free, accept, is_resolve;
   logic [SEQ_W-1:0]     seq;
   logic [TOK_COL_W-1:0] scol, dcol;
   logic                 bad_count, in_count, src_col_bad, dst_col_bad;
   logic [WORD_W-1:0]    src_blk, dst_blk;
   logic [PROD_W-1:0]    src_prod, dst_prod;
   tbl_wr_type           tbl_wr;
   tbl_rd_type           tbl_rd;

   // Flow control: each stage moves when the one after it is free
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign s2_free   = !s2_valid_ff || rsp_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_stall = !s1_free;
   assign accept    = req_valid && s1_free;
   assign csr_ready = 1'b1;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         row_bytes_ff <= RST_ROW_BYTES;
         src_width_ff <= RST_WIDTH;
         dst_width_ff <= RST_WIDTH;
         src_limit_ff <= RST_LIMIT;
         dst_limit_ff <= RST_LIMIT;
         pair_cap_ff  <= RST_PAIR_CAP;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ROW_BYTES: row_bytes_ff <= csr_data[ROW_BYTES_W-1:0];
            CSR_SRC_WIDTH: src_width_ff <= csr_data[WIDTH_REG_W-1:0];
            CSR_DST_WIDTH: dst_width_ff <= csr_data[WIDTH_REG_W-1:0];
            CSR_SRC_LIMIT: src_limit_ff <= csr_data[BLK_W-1:0];
            CSR_DST_LIMIT: dst_limit_ff <= csr_data[BLK_W-1:0];
            CSR_PAIR_CAP:  pair_cap_ff  <= csr_data[CAP_W-1:0];
            default: ;
         endcase
      end
   end

   // Request decode: sequence row, block columns and early checks
   assign seq        = req_seq_index[SEQ_W-1:0];
   assign is_resolve = (req_op == OP_RESOLVE);
   assign scol       = req_source_token[WORD_W-2:OFF_W];
   assign dcol       = req_dest_slot[WORD_W-2:OFF_W];

   assign bad_count = req_pair_count[WORD_W-1] ||
                      (req_pair_count[WORD_W-2:0] > (WORD_W-1)'(pair_cap_ff));
   assign in_count  = ((WORD_W-1)'(req_pair_index) < req_pair_count[WORD_W-2:0]);
   assign src_col_bad = (scol >= TOK_COL_W'(src_width_ff)) ||
                        (scol >= TOK_COL_W'(MAX_TABLE_COLUMNS));
   assign dst_col_bad = (dcol >= TOK_COL_W'(dst_width_ff)) ||
                        (dcol >= TOK_COL_W'(MAX_TABLE_COLUMNS));

   always_comb begin
      s1_valid_in = accept && is_resolve && (bad_count || in_count);
      if (bad_count)                     s1_status_in = ST_BAD_COUNT;
      else if (req_source_token[WORD_W-1]) s1_status_in = ST_NEG_TOK;
      else if (req_dest_slot[WORD_W-1])  s1_status_in = ST_NEG_SLOT;
      else if (src_col_bad)              s1_status_in = ST_SRC_COL;
      else if (dst_col_bad)              s1_status_in = ST_DST_COL;
      else                               s1_status_in = ST_OK;
   end

   // Table access: writes land at acceptance, resolves issue both reads
   always_comb begin
      tbl_wr.src_en = accept && (req_op == OP_WR_SRC) &&
                      (WORD_W'(req_table_column) < WORD_W'(MAX_TABLE_COLUMNS));
      tbl_wr.dst_en = accept && (req_op == OP_WR_DST) &&
                      (WORD_W'(req_table_column) < WORD_W'(MAX_TABLE_COLUMNS));
      tbl_wr.addr   = {seq, req_table_column[COL_W-1:0]};
      tbl_wr.data   = req_table_value;
      tbl_rd.en       = accept && is_resolve;
      tbl_rd.src_addr = {seq, scol[COL_W-1:0]};
      tbl_rd.dst_addr = {seq, dcol[COL_W-1:0]};
   end

   pcrar_tables u_tables (
      .clock   (clock),
      .wr      (tbl_wr),
      .rd      (tbl_rd),
      .src_blk (src_blk),
      .dst_blk (dst_blk)
   );

   // Stage 1 registers; block numbers arrive from the table read registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_status_ff <= s1_status_in;
         s1_soff_ff   <= req_source_token[OFF_W-1:0];
         s1_doff_ff   <= req_dest_slot[OFF_W-1:0];
      end
   end

   // Stage 2: block checks and row numbers
   always_comb begin
      if (s1_status_ff != ST_OK)                             s2_status_in = s1_status_ff;
      else if (src_blk[WORD_W-1])                            s2_status_in = ST_SRC_NEG;
      else if (dst_blk[WORD_W-1])                            s2_status_in = ST_DST_NEG;
      else if (src_blk[WORD_W-2:0] >= (WORD_W-1)'(src_limit_ff)) s2_status_in = ST_SRC_LIM;
      else if (dst_blk[WORD_W-2:0] >= (WORD_W-1)'(dst_limit_ff)) s2_status_in = ST_DST_LIM;
      else                                                   s2_status_in = ST_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_free) begin
         s2_status_ff <= s2_status_in;
         s2_srow_ff   <= {src_blk[BLK_W-1:0], s1_soff_ff};
         s2_drow_ff   <= {dst_blk[BLK_W-1:0], s1_doff_ff};
      end
   end

   // Stage 3: row times row size into the output register
   assign src_prod   = PROD_W'(s2_srow_ff) * PROD_W'(row_bytes_ff);
   assign dst_prod   = PROD_W'(s2_drow_ff) * PROD_W'(row_bytes_ff);
   assign rsp_src_in = (s2_status_ff == ST_OK) ? BYTE_OFF_W'(src_prod) : '0;
   assign rsp_dst_in = (s2_status_ff == ST_OK) ? BYTE_OFF_W'(dst_prod) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_free) begin
         rsp_status_ff <= s2_status_ff;
         rsp_src_ff    <= rsp_src_in;
         rsp_dst_ff    <= rsp_dst_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = rsp_status_ff;
   assign rsp_source_byte_offset = rsp_src_ff;
   assign rsp_dest_byte_offset   = rsp_dst_ff;

endmodule

### rtl/core/pcrar_tables.sv
// Source and destination block tables: one write port and one registered read port each.
// Depends on pcrar_pkg.
module pcrar_tables
   import pcrar_pkg::*;
(
   input  logic              clock,
   input  tbl_wr_type        wr,
   input  tbl_rd_type        rd,
   output logic [WORD_W-1:0] src_blk,
   output logic [WORD_W-1:0] dst_blk
);

   logic [WORD_W-1:0] src_mem [TBL_DEPTH];
   logic [WORD_W-1:0] dst_mem [TBL_DEPTH];
   logic [WORD_W-1:0] src_rd_ff;
   logic [WORD_W-1:0] dst_rd_ff;

   // Source table
   always_ff @(posedge clock) begin
      if (wr.src_en) begin
         src_mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         src_rd_ff <= src_mem[rd.src_addr];
      end
   end

   // Destination table
   always_ff @(posedge clock) begin
      if (wr.dst_en) begin
         dst_mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         dst_rd_ff <= dst_mem[rd.dst_addr];
      end
   end

   assign src_blk = src_rd_ff;
   assign dst_blk = dst_rd_ff;

endmodule

### rtl/core/pcrar_checker.sv
// Port-level checks on the resolver, bound to the top level.
// Depends on pcrar_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pcrar_checker
   import pcrar_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic [OP_W-1:0]       req_op,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [STATUS_W-1:0]   rsp_status,
   input logic [BYTE_OFF_W-1:0] rsp_source_byte_offset,
   input logic [BYTE_OFF_W-1:0] rsp_dest_byte_offset
);

   // Stalled result keeps its payload
   `ASSERT_HOLD(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, {rsp_status, rsp_source_byte_offset, rsp_dest_byte_offset}, "result payload changed under stall")

   // Failed resolves carry zero offsets
   `ASSERT_ON_CLK(a_err_zero, clock, reset, (rsp_valid && rsp_status != ST_OK) |-> (rsp_source_byte_offset == '0 && rsp_dest_byte_offset == '0), "error result with nonzero offset")

   // Only defined status codes appear
   `ASSERT_ON_CLK(a_status_range, clock, reset, rsp_valid |-> (rsp_status <= ST_DST_LIM), "undefined status code")

   // A fresh result follows an accepted resolve request
   `ASSERT_ON_CLK(a_rsp_origin, clock, reset, $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_op == OP_RESOLVE, 3), "result without a resolve request")

endmodule

bind paged_cache_row_address_resolver pcrar_checker u_pcrar_checker (.*);
